// ===== sv/sorted_list_engine_macros.svh =====
// Assertion macros shared by the checker files of the sorted list engine.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef SORTED_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_ENGINE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sle_pkg.sv =====
// Shared types, constants and helpers of the sorted list engine.
// Used by sle_cell, sorted_list_engine and sle_checker; depends on nothing.
package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int ENTRY_W  = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int OCNT_W   = 7;

    // Operation codes; code three has no meaning and is handled as search.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } t_cell_cmd;

    // Entry count as reported on the output, saturating at the field maximum.
    function automatic logic [OCNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCNT_W-1:0] wide;
        wide = {{OCNT_W{1'b0}}, cnt};
        if (wide > (CNT_W + OCNT_W)'((1 << OCNT_W) - 1)) begin
            return {OCNT_W{1'b1}};
        end
        return wide[OCNT_W-1:0];
    endfunction

endpackage

// ===== sv/sle_cell.sv =====
// One cell of the sorted chain: holds a single entry and its compare flags.
// Depends on sle_pkg for widths and the command struct.
module sle_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sle_pkg::t_cell_cmd                 i_cmd,
    input  logic                               i_occupied,
    input  logic signed [sle_pkg::ENTRY_W-1:0] i_bcast,
    input  logic                               i_prev_lt,
    input  logic signed [sle_pkg::ENTRY_W-1:0] i_prev_entry,
    input  logic signed [sle_pkg::ENTRY_W-1:0] i_next_entry,
    output logic signed [sle_pkg::ENTRY_W-1:0] o_entry,
    output logic                               o_lt,
    output logic                               o_eq
);
    import sle_pkg::*;

    logic signed [ENTRY_W-1:0] r_entry;
    logic                      r_lt;
    logic                      r_eq;

    // Compare flags are taken when a word is accepted and held for the update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_cmd.capture) begin
            r_lt <= i_occupied && (r_entry < i_bcast);
            r_eq <= i_occupied && (r_entry == i_bcast);
        end
    end

    // Cells at or past the insert point shift up; at or past the removed entry, down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !r_lt) begin
            r_entry <= i_prev_lt ? i_bcast : i_prev_entry;
        end else if (i_cmd.remove && !r_lt) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// ===== sv/sorted_list_engine.sv =====
// Sorted list engine top level: controller, result register and cell chain.
// Depends on sle_pkg and sle_cell.
//
// Keeps up to CAPACITY signed 32-bit entries in ascending order in a chain of
// cells, one entry per cell. At acceptance every cell compares its entry with
// the value at once; in the execute state, once the result register is free,
// the chain shifts by one place toward or away from the chosen position. No
// new word is taken until that update is done. The result register lets the
// next word in while a result still waits; the update of that word then waits
// until the result has been taken. Insert on a full store drops the value and
// reports full; remove deletes the first equal entry; search reports presence.
// Every result carries the entry count after the operation. No clearing pass
// is needed after reset.
module sorted_list_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sle_pkg::OP_W-1:0]           i_operation,
    input  logic signed [sle_pkg::ENTRY_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sle_pkg::ST_W-1:0]           o_status,
    output logic [sle_pkg::OCNT_W-1:0]         o_entry_count
);
    import sle_pkg::*;

    t_state                    r_state, n_state;
    logic [OP_W-1:0]           r_op;
    logic signed [ENTRY_W-1:0] r_value;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_out_valid, n_out_valid;
    logic [ST_W-1:0]           r_status, n_status;
    logic [OCNT_W-1:0]         r_out_count, n_out_count;

    t_cell_cmd                 cmd;
    logic                      accept;
    logic                      out_free;
    logic                      full;
    logic                      found;
    logic signed [ENTRY_W-1:0] bcast;

    logic signed [ENTRY_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       eq;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign found    = |eq;
    assign bcast    = (r_state == S_IDLE) ? i_value : r_value;

    // Operand register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_count <= n_out_count;
    end

    // Next state, cell commands and the result of the word in progress.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_out_count = r_out_count;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                cmd.capture = accept;
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    case (r_op)
                        OP_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                cmd.insert = 1'b1;
                                n_count    = r_count + 1'b1;
                                n_status   = ST_OK;
                            end
                        end
                        OP_REMOVE: begin
                            if (found) begin
                                cmd.remove = 1'b1;
                                n_count    = r_count - 1'b1;
                                n_status   = ST_OK;
                            end else begin
                                n_status = ST_ABSENT;
                            end
                        end
                        default: begin
                            n_status = found ? ST_OK : ST_ABSENT;
                        end
                    endcase
                    n_out_count = sat_count(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The chain of cells; the ends see a fixed neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                      prev_lt;
        logic signed [ENTRY_W-1:0] prev_entry;
        logic signed [ENTRY_W-1:0] next_entry;

        if (g == 0) begin : g_first
            assign prev_lt    = 1'b0;
            assign prev_entry = r_value;
        end else begin : g_mid
            assign prev_lt    = lt[g-1];
            assign prev_entry = entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_entry = entry[g];
        end else begin : g_inner
            assign next_entry = entry[g+1];
        end

        sle_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_bcast      (bcast),
            .i_prev_lt    (prev_lt),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_entry      (entry[g]),
            .o_lt         (lt[g]),
            .o_eq         (eq[g])
        );
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;

endmodule

// ===== sv/sle_checker.sv =====
// Port-level assertions for the sorted list engine, bound to the top level.
// Depends on sle_pkg and sorted_list_engine_macros.svh.
`include "sorted_list_engine_macros.svh"

module sle_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [sle_pkg::ST_W-1:0]   o_status,
    input logic [sle_pkg::OCNT_W-1:0] o_entry_count
);
    import sle_pkg::*;

    // A result that is not taken stays on the port.
    `SLE_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped before taken")

    // Words are never taken back to back: after a word is taken, ready drops.
    `SLE_ASSERT_NEXT(a_one_at_a_time, i_valid && o_ready, !o_ready, "word taken back to back")

    // The reported count never exceeds the store size.
    `SLE_ASSERT(a_count_range, !o_valid || (int'(o_entry_count) <= CAPACITY), "count too large")

    // A full report only comes with a full store.
    `SLE_ASSERT(a_full_count, !(o_valid && (o_status == ST_FULL)) || (int'(o_entry_count) == CAPACITY), "full status with room left")

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the sorted list engine: directed words, then random phases.
// Depends on sle_pkg and the sorted_list_engine RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import sle_pkg::*;

    // Operation code three has no meaning and must behave as a search.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [ENTRY_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ENTRY_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int TAIL_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 60;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [OCNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [ENTRY_W-1:0] value;
        logic                      typed;
        t_result                   result;
    } t_probe;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [OP_W-1:0]            i_operation = '0;
    logic signed [ENTRY_W-1:0]  i_value = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [ST_W-1:0]            o_status;
    logic [OCNT_W-1:0]          o_entry_count;

    // Shadow copy of the stored entries, in ascending order.
    logic signed [ENTRY_W-1:0]  sorted_copy[$];
    t_result                    pending_results[$];
    t_probe                     probe_rows[$];
    int                         error_count = 0;
    int                         results_seen = 0;
    logic                       rx_calm = 1'b0;
    logic                       rx_hold = 1'b0;
    bit                         tx_calm = 1'b0;

    sorted_list_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #4 i_clk = ~i_clk;

    // Apply one operation to the shadow list and return the result it must give.
    function automatic t_result apply_op(input logic [OP_W-1:0] op,
                                         input logic signed [ENTRY_W-1:0] v);
        t_result r;
        int      pos;
        pos = 0;
        r.status = ST_ABSENT;
        if (op == OP_INSERT) begin
            if (sorted_copy.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // Place ahead of the first entry that is not less than the value.
                while (pos < sorted_copy.size() && sorted_copy[pos] < v) pos++;
                sorted_copy.insert(pos, v);
                r.status = ST_OK;
            end
        end else begin
            while (pos < sorted_copy.size() && sorted_copy[pos] != v) pos++;
            if (pos < sorted_copy.size()) begin
                r.status = ST_OK;
                if (op == OP_REMOVE) sorted_copy.delete(pos);
            end
        end
        r.count = (sorted_copy.size() > 127) ? {OCNT_W{1'b1}} : OCNT_W'(sorted_copy.size());
        return r;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op,
                                    input logic signed [ENTRY_W-1:0] v,
                                    input logic typed,
                                    input logic [ST_W-1:0] st,
                                    input int cnt);
        t_probe p;
        p.op = op;
        p.value = v;
        p.typed = typed;
        p.result.status = st;
        p.result.count = OCNT_W'(cnt);
        probe_rows.push_back(p);
    endfunction

    // Sender idle length: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Value mix: stored entries for hits, a narrow band for duplicates, extremes, anything.
    function automatic logic signed [ENTRY_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && sorted_copy.size() > 0)
            return sorted_copy[$urandom_range(0, sorted_copy.size() - 1)];
        if (r < 70) return $signed(32'($urandom_range(0, 15))) - 8;
        if (r < 80) begin
            case ($urandom_range(0, 6))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return -1;
                3: return 0;
                4: return 1;
                5: return VAL_MAX - 1;
                default: return VAL_MAX;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one word after an optional gap and record its expected result once taken.
    task automatic offer_word(input logic [OP_W-1:0] op,
                              input logic signed [ENTRY_W-1:0] v,
                              input logic typed,
                              input t_result typed_result);
        int      gap;
        t_result predicted;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        predicted = apply_op(op, v);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One random phase; the weights are percentages of insert and remove.
    task automatic run_phase(input int words, input int ins_pct, input int rem_pct);
        int              r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < words; n++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) op = OP_INSERT;
            else if (r < ins_pct + rem_pct) op = OP_REMOVE;
            else op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : OP_SEARCH;
            offer_word(op, pick_value(), 1'b0, '0);
        end
        wait_drained();
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold-off.
    always @(posedge i_clk) begin
        int stall_left;
        int r;
        if (rx_hold) begin
            i_ready <= 1'b0;
        end else if (rx_calm) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_ready <= 1'b1;
            end else begin
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                i_ready <= 1'b0;
            end
        end
    end

    initial begin
        while (results_seen < HOLD_AFTER) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Result check against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d, entry_count %0d",
                       o_status, o_entry_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count mismatch: expected %0d, actual %0d",
                           want.count, o_entry_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        // Directed words: empty store, extremes, duplicates, the unused code.
        add_row(OP_SEARCH, 0,        1'b1, ST_ABSENT, 0);
        add_row(OP_REMOVE, 5,        1'b1, ST_ABSENT, 0);
        add_row(OP_UNUSED, -1,       1'b1, ST_ABSENT, 0);
        add_row(OP_INSERT, VAL_MAX,  1'b1, ST_OK,     1);
        add_row(OP_INSERT, VAL_MIN,  1'b1, ST_OK,     2);
        add_row(OP_INSERT, 0,        1'b0, ST_OK,     0);
        add_row(OP_INSERT, -1,       1'b0, ST_OK,     0);
        add_row(OP_INSERT, 0,        1'b0, ST_OK,     0);
        add_row(OP_INSERT, 1,        1'b0, ST_OK,     0);
        add_row(OP_SEARCH, VAL_MIN,  1'b1, ST_OK,     6);
        add_row(OP_SEARCH, VAL_MAX,  1'b1, ST_OK,     6);
        add_row(OP_SEARCH, 2,        1'b0, ST_OK,     0);
        add_row(OP_UNUSED, VAL_MAX,  1'b0, ST_OK,     0);
        add_row(OP_REMOVE, 0,        1'b0, ST_OK,     0);
        add_row(OP_REMOVE, 0,        1'b0, ST_OK,     0);
        add_row(OP_REMOVE, 0,        1'b0, ST_OK,     0);
        add_row(OP_REMOVE, VAL_MAX,  1'b0, ST_OK,     0);
        add_row(OP_REMOVE, VAL_MIN,  1'b0, ST_OK,     0);
        add_row(OP_SEARCH, VAL_MIN,  1'b1, ST_ABSENT, 2);
        add_row(OP_REMOVE, -1,       1'b0, ST_OK,     0);
        add_row(OP_REMOVE, 1,        1'b0, ST_OK,     0);
        add_row(OP_SEARCH, 1,        1'b1, ST_ABSENT, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_rows[k]) begin
            offer_word(probe_rows[k].op, probe_rows[k].value, probe_rows[k].typed,
                       probe_rows[k].result);
        end
        wait_drained();

        // Fill past capacity (the long receiver hold lands here), then drain to empty.
        run_phase(150, 85, 5);
        run_phase(150, 10, 80);
        // Mixed traffic; odd phases run with no idling on either side.
        for (int ph = 0; ph < 4; ph++) begin
            tx_calm = ph[0];
            rx_calm <= ph[0];
            run_phase(200, 45, 40);
        end
        tx_calm = 1'b0;
        rx_calm <= 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
